### hw/rtl/vgm_command_stream_parser_core_defines.svh
// Assertion macros shared by the parser RTL files.
`ifndef VGM_COMMAND_STREAM_PARSER_CORE_DEFINES_SVH
`define VGM_COMMAND_STREAM_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VCSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VCSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/vcsp_pkg.sv
// Shared types and constants of the VGM command stream parser.
`timescale 1ns / 1ps

package vcsp_pkg;

    // Event kinds carried on the result channel.
    typedef enum logic [1:0] {
        EVT_FM   = 2'd0,
        EVT_PSG  = 2'd1,
        EVT_WAIT = 2'd2,
        EVT_END  = 2'd3
    } t_evt_kind;

    // Configuration register indexes.
    localparam logic REG_MUTE_MASK   = 1'b0;
    localparam logic REG_LOOP_OFFSET = 1'b1;

    // Command opcodes.
    localparam logic [7:0] OP_PSG      = 8'h50;
    localparam logic [7:0] OP_FM0      = 8'h52;
    localparam logic [7:0] OP_FM1      = 8'h53;
    localparam logic [7:0] OP_WAIT_16  = 8'h61;
    localparam logic [7:0] OP_WAIT_NTSC = 8'h62;
    localparam logic [7:0] OP_WAIT_PAL = 8'h63;
    localparam logic [7:0] OP_END      = 8'h66;
    localparam logic [7:0] OP_BLOCK    = 8'h67;
    localparam logic [3:0] OP_WAIT_N   = 4'h7;
    localparam logic [3:0] OP_DAC_WAIT = 4'h8;

    // Fixed values used by the commands.
    localparam logic [15:0] WAIT_NTSC   = 16'd735;
    localparam logic [15:0] WAIT_PAL    = 16'd882;
    localparam logic [7:0]  REG_KEY_ON  = 8'h28;
    localparam logic [7:0]  REG_DAC     = 8'h2A;
    localparam logic [7:0]  DAC_VALUE   = 8'h80;
    localparam logic [31:0] LOOP_BASE   = 32'h0000_001C;

    // Configuration port sizes.
    localparam int CFG_DW = 32;
    localparam int MUTE_W = 6;

    // One result word.
    typedef struct packed {
        t_evt_kind   kind;
        logic        fm_port;
        logic [7:0]  reg_addr;
        logic [7:0]  reg_value;
        logic [15:0] wait_samples;
        logic        loop_wanted;
        logic [31:0] loop_position;
        logic        run_last;
    } t_evt;

    // A byte causes at most three result words.
    localparam int MAX_EVT = 3;
    localparam int EVT_CW  = $clog2(MAX_EVT + 1);

    // Result words produced by one accepted byte.
    typedef struct packed {
        logic [EVT_CW-1:0]  cnt;
        t_evt [MAX_EVT-1:0] slot;
    } t_push;

    // Event queue geometry.
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = $clog2(EVQ_DEPTH);
    localparam int EVQ_CW    = $clog2(EVQ_DEPTH + 1);

endpackage

### hw/rtl/vcsp_parser.sv
// Command parse state machine: turns each accepted byte into up to three result words.
`timescale 1ns / 1ps
`include "vgm_command_stream_parser_core_defines.svh"

module vcsp_parser
    import vcsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  logic [7:0]        i_byte,
    input  logic              i_fin,
    input  logic              i_wr_en,
    input  logic              i_wr_index,
    input  logic [CFG_DW-1:0] i_wr_data,
    output t_push             o_push
);

    typedef enum logic [3:0] {
        PH_OPCODE   = 4'd0,
        PH_FM_ADDR  = 4'd1,
        PH_FM_DATA  = 4'd2,
        PH_PSG_DATA = 4'd3,
        PH_WAIT_LO  = 4'd4,
        PH_WAIT_HI  = 4'd5,
        PH_BLK_HDR  = 4'd6,
        PH_BLK_LEN  = 4'd7,
        PH_BLK_DATA = 4'd8
    } t_phase;

    t_phase            r_phase, n_phase;
    logic              r_stopped, n_stopped;
    logic              r_port, n_port;
    logic [7:0]        r_addr, n_addr;
    logic [7:0]        r_lo, n_lo;
    logic [31:0]       r_blk, n_blk;
    logic [31:0]       r_skip, n_skip;
    logic [MUTE_W-1:0] r_mute;
    logic [31:0]       r_loop_offset;

    t_evt              pe0, pe1, end_evt;
    logic [EVT_CW-1:0] pcnt, cnt;
    logic              ended;
    logic [31:0]       skip_dec;
    logic [2:0]        key_ch;
    logic [MUTE_W:0]   mute_ext;
    logic              key_muted;
    t_evt [MAX_EVT-1:0] slots;

    // Build one result word; run_last is set later on the final slot.
    function automatic t_evt mk_evt(t_evt_kind kind, logic port, logic [7:0] addr,
                                    logic [7:0] val, logic [15:0] wt, logic lw,
                                    logic [31:0] lp);
        t_evt e;
        e.kind          = kind;
        e.fm_port       = port;
        e.reg_addr      = addr;
        e.reg_value     = val;
        e.wait_samples  = wt;
        e.loop_wanted   = lw;
        e.loop_position = lp;
        e.run_last      = 1'b0;
        return e;
    endfunction

    // Key-on channel code to mute bit; codes 4 and up shift down by one, so code 7 reads a zero bit.
    always_comb begin
        key_ch   = (i_byte[2:0] >= 3'd4) ? (i_byte[2:0] - 3'd1) : i_byte[2:0];
        mute_ext = {1'b0, r_mute};
        key_muted = mute_ext[key_ch];
    end

    // Parse step for the byte at the input.
    always_comb begin
        n_phase   = r_phase;
        n_stopped = r_stopped;
        n_port    = r_port;
        n_addr    = r_addr;
        n_lo      = r_lo;
        n_blk     = r_blk;
        n_skip    = r_skip;
        pe0       = '0;
        pe1       = '0;
        pcnt      = '0;
        ended     = 1'b0;
        skip_dec  = r_skip - 32'd1;
        end_evt   = mk_evt(EVT_END, 1'b0, 8'd0, 8'd0, 16'd0, 1'b0, 32'd0);

        unique case (r_phase)
            PH_OPCODE: begin
                n_port = (i_byte == OP_FM1);
                if (i_byte == OP_FM0 || i_byte == OP_FM1) begin
                    n_phase = PH_FM_ADDR;
                end else if (i_byte == OP_PSG) begin
                    n_phase = PH_PSG_DATA;
                end else if (i_byte == OP_WAIT_16) begin
                    n_phase = PH_WAIT_LO;
                end else if (i_byte == OP_WAIT_NTSC) begin
                    pe0  = mk_evt(EVT_WAIT, 1'b0, 8'd0, 8'd0, WAIT_NTSC, 1'b0, 32'd0);
                    pcnt = EVT_CW'(1);
                end else if (i_byte == OP_WAIT_PAL) begin
                    pe0  = mk_evt(EVT_WAIT, 1'b0, 8'd0, 8'd0, WAIT_PAL, 1'b0, 32'd0);
                    pcnt = EVT_CW'(1);
                end else if (i_byte == OP_END) begin
                    if (r_loop_offset != 32'd0) begin
                        pe0 = mk_evt(EVT_END, 1'b0, 8'd0, 8'd0, 16'd0, 1'b1,
                                     r_loop_offset + LOOP_BASE);
                    end else begin
                        pe0       = end_evt;
                        n_stopped = 1'b1;
                    end
                    pcnt  = EVT_CW'(1);
                    ended = 1'b1;
                end else if (i_byte == OP_BLOCK) begin
                    n_phase = PH_BLK_HDR;
                    n_skip  = 32'd2;
                end else if (i_byte[7:4] == OP_WAIT_N) begin
                    pe0  = mk_evt(EVT_WAIT, 1'b0, 8'd0, 8'd0,
                                  16'(i_byte[3:0]) + 16'd1, 1'b0, 32'd0);
                    pcnt = EVT_CW'(1);
                end else if (i_byte[7:4] == OP_DAC_WAIT) begin
                    pe0  = mk_evt(EVT_FM, 1'b0, REG_DAC, DAC_VALUE, 16'd0, 1'b0, 32'd0);
                    pe1  = mk_evt(EVT_WAIT, 1'b0, 8'd0, 8'd0, 16'(i_byte[3:0]), 1'b0,
                                  32'd0);
                    pcnt = EVT_CW'(2);
                end
            end
            PH_FM_ADDR: begin
                n_addr  = i_byte;
                n_phase = PH_FM_DATA;
            end
            PH_FM_DATA: begin
                n_phase = PH_OPCODE;
                if (!(r_addr == REG_KEY_ON && key_muted)) begin
                    pe0  = mk_evt(EVT_FM, r_port, r_addr, i_byte, 16'd0, 1'b0, 32'd0);
                    pcnt = EVT_CW'(1);
                end
            end
            PH_PSG_DATA: begin
                n_phase = PH_OPCODE;
                pe0  = mk_evt(EVT_PSG, 1'b0, 8'd0, i_byte, 16'd0, 1'b0, 32'd0);
                pcnt = EVT_CW'(1);
            end
            PH_WAIT_LO: begin
                n_lo    = i_byte;
                n_phase = PH_WAIT_HI;
            end
            PH_WAIT_HI: begin
                n_phase = PH_OPCODE;
                pe0  = mk_evt(EVT_WAIT, 1'b0, 8'd0, 8'd0, {i_byte, r_lo}, 1'b0, 32'd0);
                pcnt = EVT_CW'(1);
            end
            PH_BLK_HDR: begin
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    n_phase = PH_BLK_LEN;
                    n_blk   = 32'd0;
                    n_skip  = 32'd4;
                end
            end
            PH_BLK_LEN: begin
                // Length arrives low byte first.
                n_blk  = {i_byte, r_blk[31:8]};
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    if (n_blk == 32'd0) begin
                        n_phase = PH_OPCODE;
                    end else begin
                        n_skip  = n_blk;
                        n_phase = PH_BLK_DATA;
                    end
                end
            end
            PH_BLK_DATA: begin
                n_skip = skip_dec;
                if (skip_dec == 32'd0) begin
                    n_phase = PH_OPCODE;
                end
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase

        // The last stream byte closes the stream unless it already ended it.
        slots    = '0;
        slots[0] = pe0;
        slots[1] = pe1;
        cnt      = pcnt;
        if (i_fin && !ended) begin
            slots[pcnt] = end_evt;
            cnt         = pcnt + EVT_CW'(1);
            n_stopped   = 1'b1;
        end
        if (cnt != '0) begin
            slots[cnt - EVT_CW'(1)].run_last = 1'b1;
        end
        if (!i_acc || r_stopped) begin
            cnt = '0;
        end
        o_push.cnt  = cnt;
        o_push.slot = slots;
    end

    // Parse state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_OPCODE;
            r_stopped     <= 1'b0;
            r_mute        <= '0;
            r_loop_offset <= '0;
        end else begin
            if (i_acc && !r_stopped) begin
                r_phase   <= n_phase;
                r_stopped <= n_stopped;
            end
            if (i_wr_en) begin
                if (i_wr_index == REG_MUTE_MASK) begin
                    r_mute <= i_wr_data[MUTE_W-1:0];
                end else begin
                    r_loop_offset <= i_wr_data[31:0];
                end
            end
        end
    end

    // Operand latches.
    always_ff @(posedge i_clk) begin
        if (i_acc && !r_stopped) begin
            r_port <= n_port;
            r_addr <= n_addr;
            r_lo   <= n_lo;
            r_blk  <= n_blk;
            r_skip <= n_skip;
        end
    end

    `VCSP_ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, r_stopped, r_stopped, "parser left the stopped state")
    `VCSP_ASSERT_NOW(a_stop_silent, i_clk, i_rst_n, r_stopped, o_push.cnt == '0, "stopped parser produced a word")
    `VCSP_ASSERT_NEXT(a_fin_mid_cmd, i_clk, i_rst_n, i_acc && i_fin && r_phase != PH_OPCODE, r_stopped, "final byte inside a command did not stop the parser")

endmodule

### hw/rtl/vcsp_evt_queue.sv
// Small event queue: takes up to three words per cycle, gives one word per cycle unless stalled.
`timescale 1ns / 1ps
`include "vgm_command_stream_parser_core_defines.svh"

module vcsp_evt_queue
    import vcsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_stall,
    output t_evt  o_evt
);

    // Room for a full three-word burst is needed before the next byte is taken.
    localparam logic [EVQ_CW-1:0] FULL_AT = EVQ_CW'(EVQ_DEPTH - MAX_EVT + 1);

    t_evt [EVQ_DEPTH-1:0] r_mem;
    logic [EVQ_AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [EVQ_CW-1:0]    r_count, n_count;
    logic                 pop;

    assign pop     = (r_count != '0) && !i_stall;
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count >= FULL_AT);
    assign o_evt   = r_mem[r_rd_ptr];
    assign n_count = r_count + EVQ_CW'(i_push.cnt) - EVQ_CW'(pop);

    // Each entry takes the burst slot that lands on it.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < EVQ_DEPTH; i++) begin
            logic [EVQ_AW-1:0] k;
            k = EVQ_AW'(i) - r_wr_ptr;
            if (EVT_CW'(k) < i_push.cnt) begin
                r_mem[i] <= i_push.slot[k[EVT_CW-1:0]];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + EVQ_AW'(i_push.cnt);
            r_rd_ptr <= r_rd_ptr + EVQ_AW'(pop);
            r_count  <= n_count;
        end
    end

    `VCSP_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, 1'b1, r_count <= EVQ_CW'(EVQ_DEPTH), "event queue over capacity")
    `VCSP_ASSERT_NOW(a_push_room, i_clk, i_rst_n, i_push.cnt != '0, r_count < FULL_AT, "burst written into a queue without room")
    `VCSP_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, i_push.cnt == '0 && !pop, $stable(r_count) && $stable(r_rd_ptr), "queue moved without a push or pop")

endmodule

### hw/rtl/vgm_command_stream_parser_core.sv
// VGM command stream parser: top level with ports, parser and event queue.
`timescale 1ns / 1ps

// Takes one command stream byte per cycle and emits FM writes, PSG writes, waits and
// end words, one word per cycle, while neither side stalls. A byte is parsed in the
// cycle it is accepted and its zero to three words go into a four-entry event queue;
// the input stalls while the queue holds two or more words, so bytes that give at
// most one word each stream at one byte per cycle, and a byte that gives two or three
// words stalls the input. After an end word without a loop, or after a final byte that
// is not a looping end, further bytes are accepted and dropped until reset.
// Configuration writes are taken at any time and apply to bytes accepted after them.
module vgm_command_stream_parser_core
    import vcsp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic              i_wr_index,
    input  logic [CFG_DW-1:0] i_wr_data,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_stream_byte,
    input  logic              i_final_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_event_kind,
    output logic              o_fm_port,
    output logic [7:0]        o_reg_addr,
    output logic [7:0]        o_reg_value,
    output logic [15:0]       o_wait_samples,
    output logic              o_loop_wanted,
    output logic [31:0]       o_loop_position,
    output logic              o_run_last
);

    t_push push;
    t_evt  evt;
    logic  q_full;
    logic  acc;

    assign o_stall = q_full;
    assign acc     = i_valid && !q_full;

    // Parse state machine.
    vcsp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_byte     (i_stream_byte),
        .i_fin      (i_final_byte),
        .i_wr_en    (i_wr_en),
        .i_wr_index (i_wr_index),
        .i_wr_data  (i_wr_data),
        .o_push     (push)
    );

    // Output word queue.
    vcsp_evt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_evt   (evt)
    );

    // Result word fields.
    assign o_event_kind    = evt.kind;
    assign o_fm_port       = evt.fm_port;
    assign o_reg_addr      = evt.reg_addr;
    assign o_reg_value     = evt.reg_value;
    assign o_wait_samples  = evt.wait_samples;
    assign o_loop_wanted   = evt.loop_wanted;
    assign o_loop_position = evt.loop_position;
    assign o_run_last      = evt.run_last;

endmodule

### verif/vgm_command_stream_parser_core_tb.sv
// Self-checking testbench for the VGM command stream parser core.
`timescale 1ns / 1ps

module vgm_command_stream_parser_core_tb;
    import vcsp_pkg::*;

    // Parse phases of the expected-event model.
    typedef enum logic [3:0] {
        PS_OPCODE,
        PS_FM_ADDR,
        PS_FM_DATA,
        PS_PSG_DATA,
        PS_WAIT_LO,
        PS_WAIT_HI,
        PS_BLK_HDR,
        PS_BLK_LEN,
        PS_BLK_DATA
    } t_parse_phase;

    // Tracks the parser state, predicts the event words of every accepted
    // stream word, and checks the event words that come out of the block.
    class vgm_event_board;
        logic [5:0]   mute = '0;
        logic [31:0]  loop_offset = '0;
        t_parse_phase phase = PS_OPCODE;
        logic [7:0]   opcode = '0;
        logic [7:0]   addr_hold = '0;
        logic [7:0]   lo_hold = '0;
        logic [31:0]  blk_len = '0;
        logic [31:0]  skip_left = '0;
        bit           halted = 1'b0;
        t_evt         expected_events[$];
        int           mismatches = 0;

        function void set_reg(logic idx, logic [CFG_DW-1:0] v);
            if (idx == REG_MUTE_MASK) mute = v[MUTE_W-1:0];
            else loop_offset = v;
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        function bit at_opcode();
            return !halted && phase == PS_OPCODE;
        endfunction

        function t_evt make_word(t_evt_kind k, logic port, logic [7:0] addr,
                                 logic [7:0] val, logic [15:0] w, logic lw,
                                 logic [31:0] lp);
            t_evt e;
            e.kind          = k;
            e.fm_port       = port;
            e.reg_addr      = addr;
            e.reg_value     = val;
            e.wait_samples  = w;
            e.loop_wanted   = lw;
            e.loop_position = lp;
            e.run_last      = 1'b0;
            return e;
        endfunction

        // Channel codes 4..6 skip the gap at code 3; code 7 lands past the mask.
        function bit key_on_dropped(logic [7:0] v);
            int c;
            c = v[2:0];
            if (c >= 4) c--;
            return (c < MUTE_W) && mute[c];
        endfunction

        // Advances the parse state by one accepted stream word.
        function void note_byte(logic [7:0] b, logic fin);
            t_evt words[$];
            bit   ended;
            ended = 1'b0;
            if (halted) return;
            case (phase)
                PS_OPCODE: begin
                    opcode = b;
                    if (b == OP_FM0 || b == OP_FM1) begin
                        phase = PS_FM_ADDR;
                    end else if (b == OP_PSG) begin
                        phase = PS_PSG_DATA;
                    end else if (b == OP_WAIT_16) begin
                        phase = PS_WAIT_LO;
                    end else if (b == OP_WAIT_NTSC) begin
                        words.push_back(make_word(EVT_WAIT, 0, 0, 0, WAIT_NTSC, 0, 0));
                    end else if (b == OP_WAIT_PAL) begin
                        words.push_back(make_word(EVT_WAIT, 0, 0, 0, WAIT_PAL, 0, 0));
                    end else if (b == OP_END) begin
                        if (loop_offset != 0) begin
                            words.push_back(make_word(EVT_END, 0, 0, 0, 0, 1,
                                                      loop_offset + LOOP_BASE));
                        end else begin
                            words.push_back(make_word(EVT_END, 0, 0, 0, 0, 0, 0));
                            halted = 1'b1;
                        end
                        ended = 1'b1;
                    end else if (b == OP_BLOCK) begin
                        phase = PS_BLK_HDR;
                        skip_left = 2;
                    end else if (b[7:4] == OP_WAIT_N) begin
                        words.push_back(make_word(EVT_WAIT, 0, 0, 0,
                                                  {12'd0, b[3:0]} + 16'd1, 0, 0));
                    end else if (b[7:4] == OP_DAC_WAIT) begin
                        words.push_back(make_word(EVT_FM, 0, REG_DAC, DAC_VALUE, 0, 0, 0));
                        words.push_back(make_word(EVT_WAIT, 0, 0, 0, {12'd0, b[3:0]}, 0, 0));
                    end
                end
                PS_FM_ADDR: begin
                    addr_hold = b;
                    phase = PS_FM_DATA;
                end
                PS_FM_DATA: begin
                    phase = PS_OPCODE;
                    if (!(addr_hold == REG_KEY_ON && key_on_dropped(b)))
                        words.push_back(make_word(EVT_FM, opcode == OP_FM1, addr_hold,
                                                  b, 0, 0, 0));
                end
                PS_PSG_DATA: begin
                    phase = PS_OPCODE;
                    words.push_back(make_word(EVT_PSG, 0, 0, b, 0, 0, 0));
                end
                PS_WAIT_LO: begin
                    lo_hold = b;
                    phase = PS_WAIT_HI;
                end
                PS_WAIT_HI: begin
                    phase = PS_OPCODE;
                    words.push_back(make_word(EVT_WAIT, 0, 0, 0, {b, lo_hold}, 0, 0));
                end
                PS_BLK_HDR: begin
                    skip_left--;
                    if (skip_left == 0) begin
                        phase = PS_BLK_LEN;
                        blk_len = '0;
                        skip_left = 4;
                    end
                end
                PS_BLK_LEN: begin
                    blk_len = {b, blk_len[31:8]};
                    skip_left--;
                    if (skip_left == 0) begin
                        if (blk_len == 0) begin
                            phase = PS_OPCODE;
                        end else begin
                            skip_left = blk_len;
                            phase = PS_BLK_DATA;
                        end
                    end
                end
                PS_BLK_DATA: begin
                    skip_left--;
                    if (skip_left == 0) phase = PS_OPCODE;
                end
                default: phase = PS_OPCODE;
            endcase

            // The last word of the stream closes it unless it ended it already.
            if (fin && !ended) begin
                words.push_back(make_word(EVT_END, 0, 0, 0, 0, 0, 0));
                halted = 1'b1;
            end
            if (words.size() > 0) words[words.size() - 1].run_last = 1'b1;
            foreach (words[i]) expected_events.push_back(words[i]);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
        endtask

        // Compares one accepted event word with the oldest prediction.
        task check_event(t_evt got);
            t_evt want;
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("event word %h with nothing expected", got));
                return;
            end
            want = expected_events.pop_front();
            compare_field("event_kind", got.kind, want.kind);
            compare_field("fm_port", got.fm_port, want.fm_port);
            compare_field("reg_addr", got.reg_addr, want.reg_addr);
            compare_field("reg_value", got.reg_value, want.reg_value);
            compare_field("wait_samples", got.wait_samples, want.wait_samples);
            compare_field("loop_wanted", got.loop_wanted, want.loop_wanted);
            compare_field("loop_position", got.loop_position, want.loop_position);
            compare_field("run_last", got.run_last, want.run_last);
        endtask
    endclass

    localparam int STALL_LIMIT = 2000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_wr_en = 1'b0;
    logic              i_wr_index = REG_MUTE_MASK;
    logic [CFG_DW-1:0] i_wr_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [7:0]        i_stream_byte = '0;
    logic              i_final_byte = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [1:0]        o_event_kind;
    logic              o_fm_port;
    logic [7:0]        o_reg_addr;
    logic [7:0]        o_reg_value;
    logic [15:0]       o_wait_samples;
    logic              o_loop_wanted;
    logic [31:0]       o_loop_position;
    logic              o_run_last;

    t_evt           seen_evt;
    vgm_event_board board;
    bit             calm = 1'b0;
    int             bytes_fed = 0;
    int             idle_run = 0;

    vgm_command_stream_parser_core dut (.*);

    assign seen_evt = {o_event_kind, o_fm_port, o_reg_addr, o_reg_value, o_wait_samples,
                       o_loop_wanted, o_loop_position, o_run_last};

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Event side: check each accepted word and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) board.check_event(seen_evt);
            i_stall <= !calm && ($urandom_range(99) < 8);
        end
    end

    // Watchdog: ends the run when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_run <= 0;
            end else if (idle_run == STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_run <= idle_run + 1;
            end
        end
    end

    // Any byte but the data block opcode, so that a misaligned stream never
    // starts a block of unbounded length.
    function automatic logic [7:0] any_byte();
        logic [7:0] b;
        do b = $urandom; while (b == OP_BLOCK);
        return b;
    endfunction

    // Offers one stream word, with random idle cycles ahead of it, and waits
    // until the block takes it.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_stream_byte <= b;
        i_final_byte  <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_byte(b, fin);
        bytes_fed++;
    endtask

    // Stops feeding and waits until every predicted event word has come out.
    task automatic drain_events();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes both registers; stray upper bits ride along with the mute mask.
    task automatic write_regs(input logic [5:0] mute, input logic [31:0] loop_offset);
        logic [CFG_DW-1:0] w;
        w = $urandom;
        w[MUTE_W-1:0] = mute;
        i_wr_en    <= 1'b1;
        i_wr_index <= REG_MUTE_MASK;
        i_wr_data  <= w;
        @(posedge i_clk);
        board.set_reg(REG_MUTE_MASK, w);
        i_wr_index <= REG_LOOP_OFFSET;
        i_wr_data  <= loop_offset;
        @(posedge i_clk);
        board.set_reg(REG_LOOP_OFFSET, loop_offset);
        i_wr_en <= 1'b0;
    endtask

    // One random command, mostly well formed, sometimes stray or cut short.
    task automatic send_command();
        int pick;
        int len;
        logic [7:0] op;
        pick = $urandom_range(99);
        if (pick < 22) begin
            push_byte($urandom_range(1) ? OP_FM1 : OP_FM0, 1'b0);
            push_byte(($urandom_range(99) < 35) ? REG_KEY_ON : any_byte(), 1'b0);
            push_byte(any_byte(), 1'b0);
        end else if (pick < 30) begin
            push_byte(OP_PSG, 1'b0);
            push_byte(any_byte(), 1'b0);
        end else if (pick < 38) begin
            push_byte(OP_WAIT_16, 1'b0);
            push_byte(any_byte(), 1'b0);
            push_byte(any_byte(), 1'b0);
        end else if (pick < 42) begin
            push_byte(OP_WAIT_NTSC, 1'b0);
        end else if (pick < 46) begin
            push_byte(OP_WAIT_PAL, 1'b0);
        end else if (pick < 56) begin
            push_byte({OP_WAIT_N, 4'($urandom)}, 1'b0);
        end else if (pick < 66) begin
            push_byte({OP_DAC_WAIT, 4'($urandom)}, 1'b0);
        end else if (pick < 74) begin
            // Data block: compatibility byte, type, 32-bit length, payload.
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
            push_byte(OP_BLOCK, 1'b0);
            push_byte(OP_END, 1'b0);
            push_byte(any_byte(), 1'b0);
            push_byte(len[7:0], 1'b0);
            repeat (3) push_byte(8'h00, 1'b0);
            repeat (len) push_byte(any_byte(), 1'b0);
        end else if (pick < 80) begin
            // Looping end; the last-word flag is harmless only on an aligned end.
            push_byte(OP_END, board.at_opcode() && $urandom_range(1));
        end else if (pick < 88) begin
            push_byte(any_byte(), 1'b0);
        end else begin
            // Truncated command: the next command supplies its operands.
            case ($urandom_range(3))
                0: op = OP_FM0;
                1: op = OP_FM1;
                2: op = OP_PSG;
                default: op = OP_WAIT_16;
            endcase
            push_byte(op, 1'b0);
            repeat ($urandom_range(1)) push_byte(any_byte(), 1'b0);
        end
    endtask

    initial begin
        int start;
        int ending;
        logic [5:0] mute;
        logic [31:0] loop_offset;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Every command but the end command at its extremes, with the reset register values.
        push_byte(OP_FM0, 1'b0);
        push_byte(REG_KEY_ON, 1'b0);
        push_byte(8'hF7, 1'b0);
        push_byte(OP_FM1, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(OP_FM0, 1'b0);
        push_byte(OP_BLOCK, 1'b0);
        push_byte(OP_BLOCK, 1'b0);
        push_byte(OP_PSG, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(OP_WAIT_16, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(OP_WAIT_16, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(OP_WAIT_NTSC, 1'b0);
        push_byte(OP_WAIT_PAL, 1'b0);
        push_byte({OP_WAIT_N, 4'h0}, 1'b0);
        push_byte({OP_WAIT_N, 4'hF}, 1'b0);
        push_byte({OP_DAC_WAIT, 4'h0}, 1'b0);
        push_byte({OP_DAC_WAIT, 4'hF}, 1'b0);
        // Zero-length data block, then an opcode that does not exist.
        push_byte(OP_BLOCK, 1'b0);
        push_byte(OP_END, 1'b0);
        push_byte(8'h00, 1'b0);
        repeat (4) push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);

        // Full mute: channel code 7 still passes, others drop on both ports.
        drain_events();
        write_regs(6'h3F, 32'hFFFF_FFFF);
        push_byte(OP_FM0, 1'b0);
        push_byte(REG_KEY_ON, 1'b0);
        push_byte(8'h07, 1'b0);
        push_byte(OP_FM1, 1'b0);
        push_byte(REG_KEY_ON, 1'b0);
        push_byte(8'hF4, 1'b0);
        push_byte(OP_FM0, 1'b0);
        push_byte(REG_KEY_ON, 1'b0);
        push_byte(8'h00, 1'b0);
        // Looping end that also carries the last-word flag: the stream goes on.
        push_byte(OP_END, 1'b1);

        // Random phases; the loop offset stays nonzero so the stream never stops.
        for (int p = 0; p < 6; p++) begin
            drain_events();
            mute = (p == 0) ? 6'h00 : (p == 1) ? 6'h3F : 6'($urandom);
            case (p)
                0: loop_offset = 32'h0000_0001;
                1: loop_offset = 32'hFFFF_FFFF;
                2: loop_offset = 32'hFFFF_FFE4;
                default: begin
                    loop_offset = $urandom;
                    if (loop_offset == 0) loop_offset = 32'h0000_1000;
                end
            endcase
            write_regs(mute, loop_offset);
            calm = (p == 3);
            start = bytes_fed;
            while (bytes_fed - start < 70) send_command();
        end
        calm = 1'b0;

        // Close the stream one of three ways, then feed words that are dropped.
        drain_events();
        ending = $urandom_range(2);
        if (ending == 0) begin
            write_regs(6'($urandom), 32'h0000_0000);
            push_byte(OP_END, $urandom_range(1));
        end else if (ending == 1) begin
            push_byte(OP_FM0, 1'b0);
            push_byte(REG_KEY_ON, 1'b1);
        end else begin
            push_byte({OP_WAIT_N, 4'h2}, 1'b1);
        end
        repeat (4) push_byte(any_byte(), $urandom_range(1));

        drain_events();
        repeat (12) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
